@@ rtl/core/scfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sync character frame extractor package
// Shared types and constants: configuration fields, register indexes and the
// layout of one result beat.
// ----------------------------------------------------------------------------
package scfe_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned LenW    = 11;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDatW = 11;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_SYNC_CHAR   = 3'd0,
      CSR_DATA_MARK_A = 3'd1,
      CSR_DATA_MARK_B = 3'd2,
      CSR_CTRL_LEN    = 3'd3,
      CSR_DATA_LEN    = 3'd4
   } csr_index_type;

   // Current configuration, as seen by the parser.
   typedef struct packed {
      logic [ByteW-1:0] sync_char;
      logic [ByteW-1:0] data_mark_a;
      logic [ByteW-1:0] data_mark_b;
      logic [LenW-1:0]  control_frame_len;
      logic [LenW-1:0]  data_frame_len;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic             last_of_frame;
      logic             first_of_frame;
      logic             frame_kind;
      logic [ByteW-1:0] out_byte;
   } rslt_type;

   // Results produced by one input byte: zero, one or two of them.
   typedef struct packed {
      logic [1:0]        count;
      rslt_type [1:0]    item;
   } push_type;

endpackage
`default_nettype wire

@@ rtl/core/scfe_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the sync character, the two data marks and the two frame lengths,
// written through a valid/ready port by register index.
// ----------------------------------------------------------------------------
module scfe_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [scfe_pkg::CsrIdxW-1:0]     csr_index,
   input  wire  [scfe_pkg::CsrDatW-1:0]     csr_data,
   output scfe_pkg::cfg_type                cfg
);
   import scfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // The port never stalls.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_CHAR:   cfg_in.sync_char         = csr_data[ByteW-1:0];
            CSR_DATA_MARK_A: cfg_in.data_mark_a       = csr_data[ByteW-1:0];
            CSR_DATA_MARK_B: cfg_in.data_mark_b       = csr_data[ByteW-1:0];
            CSR_CTRL_LEN:    cfg_in.control_frame_len = csr_data[LenW-1:0];
            CSR_DATA_LEN:    cfg_in.data_frame_len    = csr_data[LenW-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_char         <= ByteW'(22);
         cfg_ff.data_mark_a       <= ByteW'(17);
         cfg_ff.data_mark_b       <= ByteW'(18);
         cfg_ff.control_frame_len <= LenW'(2);
         cfg_ff.data_frame_len    <= LenW'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/scfe_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser
// Hunts for the sync character, classifies the frame by its second byte and
// counts frame bytes, producing up to two result beats per input byte.
// ----------------------------------------------------------------------------
module scfe_parser #(
   parameter int unsigned MAX_FRAME_LEN = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              accept,
   input  wire  [scfe_pkg::ByteW-1:0]       in_byte,
   input  wire  scfe_pkg::cfg_type          cfg,
   output scfe_pkg::push_type               push
);
   import scfe_pkg::*;

   localparam int unsigned  CmpW   = 17;
   localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_FRAME_LEN);
   localparam logic [CmpW-1:0] MinLen = CmpW'(2);

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC  = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [LenW-1:0] count_ff, count_in;
   logic            kind_ff, kind_in;

   logic            mark_hit;
   logic [CmpW-1:0] len_sync;
   logic [CmpW-1:0] len_frame;
   logic [LenW-1:0] count_inc;
   logic            last_sync;
   logic            last_frame;

   // Clamp a programmed length to the range 2 .. MAX_FRAME_LEN.
   function automatic logic [CmpW-1:0] clamp_len(input logic [LenW-1:0] raw);
      logic [CmpW-1:0] wide;
      wide = CmpW'(raw);
      if (wide < MinLen) begin
         wide = MinLen;
      end else if (wide > MaxLen) begin
         wide = MaxLen;
      end
      return wide;
   endfunction

   // Frame length and end test for both the second byte and later bytes.
   assign mark_hit   = (in_byte == cfg.data_mark_a) || (in_byte == cfg.data_mark_b);
   assign len_sync   = mark_hit ? clamp_len(cfg.data_frame_len)
                                : clamp_len(cfg.control_frame_len);
   assign len_frame  = kind_ff ? clamp_len(cfg.data_frame_len)
                               : clamp_len(cfg.control_frame_len);
   assign last_sync  = (len_sync == MinLen);
   assign count_inc  = count_ff + LenW'(1);
   assign last_frame = (CmpW'(count_inc) >= len_frame);

   // Next state and result beats for the accepted byte.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      push.count = 2'd0;
      push.item  = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC: begin
               kind_in                      = mark_hit;
               push.count                   = 2'd2;
               push.item[0].out_byte        = cfg.sync_char;
               push.item[0].frame_kind      = mark_hit;
               push.item[0].first_of_frame  = 1'b1;
               push.item[0].last_of_frame   = 1'b0;
               push.item[1].out_byte        = in_byte;
               push.item[1].frame_kind      = mark_hit;
               push.item[1].first_of_frame  = 1'b0;
               push.item[1].last_of_frame   = last_sync;
               if (last_sync) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  phase_in = PH_FRAME;
                  count_in = LenW'(2);
               end
            end
            PH_FRAME: begin
               push.count                   = 2'd1;
               push.item[0].out_byte        = in_byte;
               push.item[0].frame_kind      = kind_ff;
               push.item[0].first_of_frame  = 1'b0;
               push.item[0].last_of_frame   = last_frame;
               if (last_frame) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            default: begin
               count_in = '0;
               phase_in = (in_byte == cfg.sync_char) ? PH_SYNC : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         kind_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
      end
   end

   // Inside a frame at least the sync byte and the second byte have gone out.
   a_frame_count : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FRAME) |-> (count_ff >= LenW'(2)))
      else $error("frame phase with a byte count below two");

   // The last beat of a frame sends the parser back to hunting.
   a_last_hunts : assert property (@(posedge clock) disable iff (reset)
      (accept && (push.count != 2'd0) &&
       push.item[push.count[1]].last_of_frame) |=> (phase_ff == PH_HUNT))
      else $error("parser did not resume hunting after the last beat");

   // A byte taken while hunting never produces a result.
   a_hunt_silent : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (push.count == 2'd0))
      else $error("result produced while hunting");

endmodule
`default_nettype wire

@@ rtl/core/scfe_rsp_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Four-entry register queue that takes up to two result beats per cycle while
// two entries are free, and hands out one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module scfe_rsp_fifo (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  scfe_pkg::push_type         push,
   output logic                             room,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output scfe_pkg::rslt_type               rsp_item
);
   import scfe_pkg::*;

   localparam int unsigned Depth = 4;
   localparam int unsigned PtrW  = 2;
   localparam int unsigned CntW  = 3;

   rslt_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   // Room for a full two-beat burst keeps the input side open.
   assign room       = (count_ff <= CntW'(Depth - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_item   = mem_ff[rd_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   // Pointer and fill-level update.
   always_comb begin
      wr_in    = wr_ff + PtrW'(push.count);
      rd_in    = rd_ff + PtrW'(pop);
      count_in = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage for the queued beats.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + PtrW'(1)] <= push.item[1];
      end
   end

   // The queue never holds more beats than it has entries.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue overflow");

   // Beats only arrive while there is room for a full burst.
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("beats pushed without room");

   // Fill level and pointers stay consistent.
   a_level : assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == count_ff[PtrW-1:0])
      else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

@@ rtl/core/sync_char_frame_extractor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sync character frame extractor
// Cuts a stream of received bytes into control and data frames opened by a
// programmable sync character.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat on the req_ channel and, while
// not space-limited, accepts a byte every cycle. Bytes outside a frame are
// dropped until the sync character arrives; the following byte selects a data
// frame (either data mark) or a control frame, and frame beats leave on the
// rsp_ channel one per cycle while rsp_tready is high. The sync beat is
// released with the second byte, so that byte yields two beats; a four-entry
// result queue absorbs the burst and req_tready falls only while fewer than
// two entries are free. Frame lengths count the sync byte and are clamped to
// 2 .. MAX_FRAME_LEN.
module sync_char_frame_extractor #(
   parameter int unsigned MAX_FRAME_LEN = 1024
) (
   input  wire         clock,
   input  wire         reset,
   // Received bytes.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   // Frame beats.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] frame_kind, [1] first_of_frame
   output logic        rsp_tlast,   // last_of_frame
   // Configuration writes.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [10:0] csr_data
);
   import scfe_pkg::*;

   cfg_type  cfg;
   push_type push;
   rslt_type rsp_item;
   logic     room;
   logic     accept;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   scfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scfe_parser #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .cfg     (cfg),
      .push    (push)
   );

   scfe_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Result beat to stream fields.
   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tuser = {rsp_item.first_of_frame, rsp_item.frame_kind};
   assign rsp_tlast = rsp_item.last_of_frame;

endmodule
`default_nettype wire

@@ bench/scfe_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sync character frame extractor checker
// Watches the byte, frame and register channels. It keeps its own copy of the
// parser state and registers, works out the frame beats for every accepted
// byte, and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module scfe_checker #(
   parameter int unsigned MAX_FRAME_LEN = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [7:0]  rsp_tdata,   // [7:0] out_byte
   input  wire  [1:0]  rsp_tuser,   // [0] frame_kind, [1] first_of_frame
   input  wire         rsp_tlast,   // last_of_frame
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [10:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          bytes_accepted,
   output int          beats_checked,
   output int          control_frames,
   output int          data_frames
);
   import scfe_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT     = 2'd0,
      PH_SYNC     = 2'd1,
      PH_IN_FRAME = 2'd2
   } parse_phase_type;

   cfg_type          cfg;
   parse_phase_type  phase;
   logic [LenW-1:0]  byte_count;
   logic             data_frame;
   rslt_type         frame_beats[$];
   rslt_type         got_beat;
   rslt_type         want_beat;

   // Length of the current frame, held to the legal range.
   function automatic logic [LenW-1:0] frame_limit();
      logic [LenW-1:0] len;
      len = data_frame ? cfg.data_frame_len : cfg.control_frame_len;
      if (len < 2) len = LenW'(2);
      else if (len > MAX_FRAME_LEN) len = LenW'(MAX_FRAME_LEN);
      return len;
   endfunction

   // Advances the parser by one received byte and queues the beats it releases.
   function automatic void predict_frame_beats(input logic [ByteW-1:0] rx);
      logic     closes;
      rslt_type beat;
      closes = 1'b0;
      case (phase)
         PH_SYNC: begin
            // The held sync byte goes out together with the kind byte.
            data_frame = (rx == cfg.data_mark_a) || (rx == cfg.data_mark_b);
            closes = (frame_limit() <= 2);
            beat = '{last_of_frame: 1'b0, first_of_frame: 1'b1,
                     frame_kind: data_frame, out_byte: cfg.sync_char};
            frame_beats = {frame_beats, beat};
            beat = '{last_of_frame: closes, first_of_frame: 1'b0,
                     frame_kind: data_frame, out_byte: rx};
            frame_beats = {frame_beats, beat};
            byte_count = LenW'(2);
            phase = PH_IN_FRAME;
         end
         PH_IN_FRAME: begin
            // The length is read on every byte, so a shorter one ends the frame at once.
            byte_count = byte_count + 1'b1;
            closes = (byte_count >= frame_limit());
            beat = '{last_of_frame: closes, first_of_frame: 1'b0,
                     frame_kind: data_frame, out_byte: rx};
            frame_beats = {frame_beats, beat};
         end
         default: begin
            byte_count = '0;
            phase = (rx == cfg.sync_char) ? PH_SYNC : PH_HUNT;
         end
      endcase
      if (closes) begin
         phase = PH_HUNT;
         byte_count = '0;
         if (data_frame) data_frames++;
         else control_frames++;
      end
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40) $display("[%0t] frame check: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{sync_char: 8'd22, data_mark_a: 8'd17, data_mark_b: 8'd18,
                 control_frame_len: 11'd2, data_frame_len: 11'd1024};
         phase = PH_HUNT;
         byte_count = '0;
         data_frame = 1'b0;
         frame_beats.delete();
      end else begin
         // A byte taken at this edge still sees the registers as they were.
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            predict_frame_beats(req_tdata);
         end
         // Register writes must come only while the parser has nothing in flight; the block does not enforce it.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_CHAR:   cfg.sync_char = csr_data[ByteW-1:0];
               CSR_DATA_MARK_A: cfg.data_mark_a = csr_data[ByteW-1:0];
               CSR_DATA_MARK_B: cfg.data_mark_b = csr_data[ByteW-1:0];
               CSR_CTRL_LEN:    cfg.control_frame_len = csr_data[LenW-1:0];
               CSR_DATA_LEN:    cfg.data_frame_len = csr_data[LenW-1:0];
               default: ;
            endcase
         end
         // Each returned beat is matched against the oldest one predicted.
         if (rsp_tvalid && rsp_tready) begin
            got_beat = '{last_of_frame: rsp_tlast, first_of_frame: rsp_tuser[1],
                         frame_kind: rsp_tuser[0], out_byte: rsp_tdata};
            if (frame_beats.size() == 0) begin
               report_mismatch($sformatf("beat with byte 0x%02h and none pending", rsp_tdata));
            end else begin
               want_beat = frame_beats.pop_front();
               beats_checked++;
               if (got_beat.out_byte !== want_beat.out_byte)
                  report_mismatch($sformatf("beat %0d byte 0x%02h, want 0x%02h", beats_checked,
                                            got_beat.out_byte, want_beat.out_byte));
               if (got_beat.frame_kind !== want_beat.frame_kind)
                  report_mismatch($sformatf("beat %0d kind %b, want %b", beats_checked,
                                            got_beat.frame_kind, want_beat.frame_kind));
               if (got_beat.first_of_frame !== want_beat.first_of_frame)
                  report_mismatch($sformatf("beat %0d first %b, want %b", beats_checked,
                                            got_beat.first_of_frame, want_beat.first_of_frame));
               if (got_beat.last_of_frame !== want_beat.last_of_frame)
                  report_mismatch($sformatf("beat %0d last %b, want %b", beats_checked,
                                            got_beat.last_of_frame, want_beat.last_of_frame));
            end
         end
      end
      pending <= frame_beats.size();
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sync character frame extractor testbench
// Feeds received bytes and register writes into the extractor, with random
// gaps on the byte side and random back-pressure on the frame side, and takes
// the verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
   import scfe_pkg::*;

   localparam int MaxFrameLen = 1024;
   localparam int ItemTarget  = 1850;
   localparam int CsrIdxTop   = (1 << CsrIdxW) - 1;
   localparam int CsrDatTop   = (1 << CsrDatW) - 1;
   localparam int DrainCycles = 4;
   localparam int TailCycles  = 16;
   localparam int RunLimitNs  = 4_000_000;
   localparam logic [CsrIdxW-1:0] CsrUnusedIdx = CsrIdxW'(CSR_DATA_LEN + 1);

   // Frame kinds the frame generator can be asked for.
   localparam int KIND_ANY  = 0;
   localparam int KIND_CTRL = 1;
   localparam int KIND_DATA = 2;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic [1:0]  rsp_tuser;         // [0] frame_kind, [1] first_of_frame
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [10:0] csr_data   = '0;

   int fail_count;
   int pending;
   int bytes_accepted;
   int beats_checked;
   int control_frames;
   int data_frames;

   int send_idle_pct = 36;
   int recv_idle_pct = 74;
   int bytes_sent    = 0;
   int csr_writes    = 0;

   // Register values as last written, used to build well-formed frames.
   logic [ByteW-1:0] cur_sync     = 8'd22;
   logic [ByteW-1:0] cur_mark_a   = 8'd17;
   logic [ByteW-1:0] cur_mark_b   = 8'd18;
   logic [LenW-1:0]  cur_ctrl_len = 11'd2;
   logic [LenW-1:0]  cur_data_len = 11'd1024;

   sync_char_frame_extractor #(
      .MAX_FRAME_LEN(MaxFrameLen)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   scfe_checker #(
      .MAX_FRAME_LEN(MaxFrameLen)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .bytes_accepted (bytes_accepted),
      .beats_checked  (beats_checked),
      .control_frames (control_frames),
      .data_frames    (data_frames)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Frame side back-pressure, redrawn every cycle.
   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #(RunLimitNs);
      $display("TB_ERROR");
      $finish;
   end

   // Offers one byte, after a random gap, and holds it until it is taken.
   task automatic send_byte(input logic [ByteW-1:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Waits until every predicted beat has come back and the parser has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SYNC_CHAR:   cur_sync = val[ByteW-1:0];
         CSR_DATA_MARK_A: cur_mark_a = val[ByteW-1:0];
         CSR_DATA_MARK_B: cur_mark_b = val[ByteW-1:0];
         CSR_CTRL_LEN:    cur_ctrl_len = val[LenW-1:0];
         CSR_DATA_LEN:    cur_data_len = val[LenW-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Sends a little line noise and then one frame, optionally stopped short.
   task automatic send_frame(input int kind_sel, input bit cut);
      logic [ByteW-1:0] second;
      int               len;
      int               after;
      repeat ($urandom_range(2)) begin
         do second = ByteW'($urandom_range(255)); while (second == cur_sync);
         send_byte(second);
      end
      case (kind_sel)
         KIND_DATA: second = $urandom_range(1) ? cur_mark_a : cur_mark_b;
         KIND_CTRL: do second = ByteW'($urandom_range(255));
                    while (second == cur_mark_a || second == cur_mark_b);
         default: begin
            case ($urandom_range(9))
               0, 1, 2: second = cur_mark_a;
               3, 4, 5: second = cur_mark_b;
               6:       second = cur_sync;
               default: second = ByteW'($urandom_range(255));
            endcase
         end
      endcase
      len = (second == cur_mark_a || second == cur_mark_b) ? int'(cur_data_len)
                                                            : int'(cur_ctrl_len);
      if (len < 2) len = 2;
      else if (len > MaxFrameLen) len = MaxFrameLen;
      // Bytes after the sync byte; a cut frame stops before its last one.
      after = len - 1;
      if (cut) after = int'($urandom_range((after > 40) ? 40 : after - 1));
      send_byte(cur_sync);
      if (after > 0) send_byte(second);
      repeat ((after > 1) ? after - 1 : 0) send_byte(ByteW'($urandom_range(255)));
   endtask

   initial begin
      int                 mode;
      logic [CsrIdxW-1:0] idx;
      logic [CsrDatW-1:0] val;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes dropped while hunting, shortest control frame, sync byte as kind byte.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'd17);
      send_byte(cur_sync);
      send_byte(8'hA5);
      send_byte(cur_sync);
      send_byte(cur_sync);
      wait_drained();

      // Both data marks, and a control length below range.
      write_csr(CSR_DATA_LEN, 11'd3);
      write_csr(CSR_CTRL_LEN, 11'd0);
      send_byte(cur_sync);
      send_byte(cur_mark_a);
      send_byte(8'hFF);
      send_byte(cur_sync);
      send_byte(cur_mark_b);
      send_byte(8'h00);
      wait_drained();

      // Registers at their extremes; upper data bits of byte registers are dropped,
      // and a write to an unused index is ignored.
      write_csr(CSR_SYNC_CHAR, 11'h0FF);
      write_csr(CSR_DATA_MARK_A, 11'h000);
      write_csr(CSR_DATA_MARK_B, 11'h7FF);
      write_csr(CSR_CTRL_LEN, 11'd1);
      write_csr(CSR_DATA_LEN, 11'd4);
      write_csr(CsrUnusedIdx, 11'h155);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      // Here the sync value is also a data mark, so it opens a data frame.
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h07);
      send_byte(8'h08);
      wait_drained();
      write_csr(CSR_SYNC_CHAR, 11'd0);
      send_byte(8'h00);
      send_byte(8'h09);
      wait_drained();

      // Longest data frame: an over-range length is held at the maximum.
      write_csr(CSR_DATA_LEN, CsrDatW'(CsrDatTop));
      send_frame(KIND_DATA, 1'b0);
      wait_drained();
      // Control length just past the maximum, frame cut short, then shortened so
      // the open frame closes on its next byte.
      write_csr(CSR_CTRL_LEN, CsrDatW'(MaxFrameLen + 1));
      send_frame(KIND_CTRL, 1'b1);
      wait_drained();
      write_csr(CSR_CTRL_LEN, 11'd3);
      write_csr(CSR_DATA_LEN, 11'd6);

      // Random episodes: new register values, then mostly well-formed frames.
      while (bytes_sent < ItemTarget) begin
         mode = bytes_sent * 3 / ItemTarget;
         case (mode)
            0:       begin send_idle_pct = 36; recv_idle_pct = 74; end
            1:       begin send_idle_pct = 74; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         wait_drained();
         repeat ($urandom_range(3, 1)) begin
            idx = CsrIdxW'($urandom_range(CsrIdxTop));
            if (idx == CSR_CTRL_LEN || idx == CSR_DATA_LEN) begin
               case ($urandom_range(9))
                  0:       val = CsrDatW'($urandom_range(1));
                  1, 2:    val = CsrDatW'($urandom_range(40, 11));
                  default: val = CsrDatW'($urandom_range(10, 2));
               endcase
            end else if ($urandom_range(3) == 0) begin
               val = CsrDatW'($urandom_range(CsrDatTop));
            end else begin
               val = CsrDatW'($urandom_range(255));
            end
            write_csr(idx, val);
         end
         repeat ($urandom_range(8, 2)) begin
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(6, 1)) send_byte(ByteW'($urandom_range(255)));
            else
               send_frame(KIND_ANY, $urandom_range(5) == 0);
         end
      end

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      $display("Run covered %0d accepted bytes and %0d register writes; %0d frame beats checked.",
               bytes_accepted, csr_writes, beats_checked);
      $display("Frames closed: %0d control, %0d data; %0d mismatches.",
               control_frames, data_frames, fail_count);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/scfe_pkg.sv
rtl/core/scfe_csr.sv
rtl/core/scfe_parser.sv
rtl/core/scfe_rsp_fifo.sv
rtl/core/sync_char_frame_extractor.sv
bench/scfe_checker.sv
bench/tb_top.sv
